FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sat_pkg.sv
`default_nettype none

package sat_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int SIZE_W     = 13;
  localparam int PIXEL_W    = 8;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 40;
  localparam int ROW_SUM_W  = 20;
  localparam int ROW_SQ_W   = 28;
  localparam int CFG_IDX_W  = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] MAX_WIDTH_SIZE  = SIZE_W'(MAX_COLUMNS);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_SIZE = SIZE_W'(MAX_ROWS);

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic                 first_row;
    logic [ROW_SUM_W-1:0] row_sum;
    logic [ROW_SQ_W-1:0]  row_sq;
    logic                 eor;
    logic                 eof;
  } sat_item_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sat_ram.sv
`default_nettype none

module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sat_fifo.sv
`default_nettype none

module sat_fifo
  import sat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sat_item_t         push_item,
  input  logic              pop,
  output sat_item_t         head_item,
  output logic              empty,
  output logic              full,
  output logic [QCNT_W-1:0] count
);

  sat_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + QPTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + QPTR_W'(1)) : rd_ptr_r;
    count_nxt  = QCNT_W'(count_r + QCNT_W'(push) - QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item = slot_r[rd_ptr_r];
  assign empty     = (count_r == '0);
  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign count     = count_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sat_front.sv
`default_nettype none

module sat_front
  import sat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIXEL_W-1:0]   in_pixel,
  input  logic                 q_full,
  output logic                 q_push,
  output sat_item_t            q_item
);

  logic [SIZE_W-1:0]    frame_width_r, frame_width_nxt;
  logic [SIZE_W-1:0]    frame_height_r, frame_height_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [ROW_SUM_W-1:0] row_sum_r, row_sum_nxt;
  logic [ROW_SQ_W-1:0]  row_sq_r, row_sq_nxt;

  logic [SIZE_W-1:0]    width_eff;
  logic [SIZE_W-1:0]    height_eff;
  logic                 eor;
  logic                 eof;
  logic [2*PIXEL_W-1:0] pixel_sq;
  logic [ROW_SUM_W-1:0] sum_now;
  logic [ROW_SQ_W-1:0]  sq_now;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff  = clamp_size(frame_width_r, MAX_WIDTH_SIZE);
    height_eff = clamp_size(frame_height_r, MAX_HEIGHT_SIZE);
    eor        = (SIZE_W'(col_r) + SIZE_W'(1)) >= width_eff;
    eof        = eor && ((SIZE_W'(row_r) + SIZE_W'(1)) >= height_eff);
    pixel_sq   = in_pixel * in_pixel;
    sum_now    = row_sum_r + ROW_SUM_W'(in_pixel);
    sq_now     = row_sq_r + ROW_SQ_W'(pixel_sq);

    q_item.col       = col_r;
    q_item.first_row = (row_r == '0);
    q_item.row_sum   = sum_now;
    q_item.row_sq    = sq_now;
    q_item.eor       = eor;
    q_item.eof       = eof;

    col_nxt     = col_r;
    row_nxt     = row_r;
    row_sum_nxt = row_sum_r;
    row_sq_nxt  = row_sq_r;
    if (q_push) begin
      if (eor) begin
        col_nxt     = '0;
        row_sum_nxt = '0;
        row_sq_nxt  = '0;
        row_nxt     = eof ? '0 : ROW_W'(row_r + ROW_W'(1));
      end else begin
        col_nxt     = COL_W'(col_r + COL_W'(1));
        row_sum_nxt = sum_now;
        row_sq_nxt  = sq_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= MAX_WIDTH_SIZE;
      frame_height_r <= MAX_HEIGHT_SIZE;
      col_r          <= '0;
      row_r          <= '0;
      row_sum_r      <= '0;
      row_sq_r       <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      row_sum_r      <= row_sum_nxt;
      row_sq_r       <= row_sq_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sat_back.sv
`default_nettype none

module sat_back
  import sat_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  sat_item_t        q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SUM_W-1:0] out_area_sum,
  output logic [SQ_W-1:0]  out_area_square_sum,
  output logic             out_end_of_row,
  output logic             out_end_of_frame
);

  logic             s1_valid_r, s1_valid_nxt;
  sat_item_t        s1_item_r;
  logic             fwd_r;
  logic [SUM_W-1:0] fwd_sum_r;
  logic [SQ_W-1:0]  fwd_sq_r;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r;
  logic [SQ_W-1:0]  out_sq_r;
  logic             out_eor_r;
  logic             out_eof_r;

  logic             s1_adv;
  logic             s1_open;
  logic [SUM_W-1:0] ram_sum;
  logic [SQ_W-1:0]  ram_sq;
  logic [SUM_W-1:0] up_sum;
  logic [SQ_W-1:0]  up_sq;
  logic [SUM_W-1:0] area_sum;
  logic [SQ_W-1:0]  area_sq;

  always_comb begin
    s1_adv  = s1_valid_r && (!out_valid_r || out_ready);
    s1_open = !s1_valid_r || s1_adv;
    q_pop   = !q_empty && s1_open;

    if (s1_item_r.first_row) begin
      up_sum = '0;
      up_sq  = '0;
    end else if (fwd_r) begin
      up_sum = fwd_sum_r;
      up_sq  = fwd_sq_r;
    end else begin
      up_sum = ram_sum;
      up_sq  = ram_sq;
    end
    area_sum = up_sum + SUM_W'(s1_item_r.row_sum);
    area_sq  = up_sq + SQ_W'(s1_item_r.row_sq);

    s1_valid_nxt  = s1_open ? q_pop : s1_valid_r;
    out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  sat_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLUMNS)
  ) u_sum_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_item_r.col),
    .wdata (area_sum),
    .re    (q_pop),
    .raddr (q_item.col),
    .rdata (ram_sum)
  );

  sat_ram #(
    .WIDTH (SQ_W),
    .DEPTH (MAX_COLUMNS)
  ) u_square_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_item_r.col),
    .wdata (area_sq),
    .re    (q_pop),
    .raddr (q_item.col),
    .rdata (ram_sq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        // same column written this cycle: the ram read returns stale data
        fwd_r <= s1_adv && (q_item.col == s1_item_r.col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
      fwd_sum_r <= area_sum;
      fwd_sq_r  <= area_sq;
    end
    if (s1_adv) begin
      out_sum_r <= area_sum;
      out_sq_r  <= area_sq;
      out_eor_r <= s1_item_r.eor;
      out_eof_r <= s1_item_r.eof;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_area_sum        = out_sum_r;
  assign out_area_square_sum = out_sq_r;
  assign out_end_of_row      = out_eor_r;
  assign out_end_of_frame    = out_eof_r;

endmodule

`default_nettype wire

FILE: hw/rtl/summed_area_table_with_squares_unit.sv
// channel  direction  handshake                payload
// cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
// in       in         in_valid / in_ready      in_pixel
// out      out        out_valid / out_ready    out_area_sum, out_area_square_sum,
//                                              out_end_of_row, out_end_of_frame
//
// one pixel per cycle sustained while out_ready stays high; after its input transfer a result
// passes front into queue, line-store read, add and output register
// the single-port-write line store is read one row behind and written once per pixel
// reset is synchronous and active low; no clearing pass, cfg_ready is always high
// a stalled output fills the back stage, then the 4-entry queue, then in_ready drops
`default_nettype none

`include "assert_macros.svh"

module summed_area_table_with_squares_unit
  import sat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIXEL_W-1:0]   in_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SUM_W-1:0]     out_area_sum,
  output logic [SQ_W-1:0]      out_area_square_sum,
  output logic                 out_end_of_row,
  output logic                 out_end_of_frame
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;
  sat_item_t         q_in_item;
  sat_item_t         q_head_item;

  sat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  sat_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  sat_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_item              (q_head_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_area_sum        (out_area_sum),
    .out_area_square_sum (out_area_square_sum),
    .out_end_of_row      (out_end_of_row),
    .out_end_of_frame    (out_end_of_frame)
  );

  `SAT_ASSERT_NOW(a_eof_is_eor, out_valid && out_end_of_frame, out_end_of_row, "end of frame without end of row")
  `SAT_ASSERT_NOW(a_queue_level, rst_n && $past(rst_n), q_count == QCNT_W'($past(q_count) + QCNT_W'($past(q_push)) - QCNT_W'($past(q_pop))), "queue level lost track of transfers")
  `SAT_ASSERT_NEXT(a_pop_drains, q_pop && !q_push && (q_count == QCNT_W'(1)), q_empty, "queue not empty after last pop")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sat_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef struct {
    logic [SUM_W-1:0] area_sum;
    logic [SQ_W-1:0]  area_square_sum;
    logic             end_of_row;
    logic             end_of_frame;
  } area_result_t;

  class integral_tracker;
    logic [SIZE_W-1:0]    width_reg;
    logic [SIZE_W-1:0]    height_reg;
    logic [SUM_W-1:0]     sum_line[MAX_COLUMNS];
    logic [SQ_W-1:0]      square_line[MAX_COLUMNS];
    logic [ROW_SUM_W-1:0] row_sum;
    logic [ROW_SQ_W-1:0]  row_square_sum;
    int                   col;
    int                   row;
    area_result_t         pending_areas[$];
    int                   errors;
    int                   pixels;
    int                   results;
    int                   frames;
    int                   writes;

    function new();
      width_reg      = MAX_WIDTH_SIZE;
      height_reg     = MAX_HEIGHT_SIZE;
      row_sum        = '0;
      row_square_sum = '0;
      col            = 0;
      row            = 0;
      errors         = 0;
      pixels         = 0;
      results        = 0;
      frames         = 0;
      writes         = 0;
    endfunction

    function int eff_size(logic [SIZE_W-1:0] v, int maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      writes++;
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = data;
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void predict_pixel(logic [PIXEL_W-1:0] p);
      int               w;
      int               h;
      area_result_t     r;
      logic [SUM_W-1:0] up_sum;
      logic [SQ_W-1:0]  up_square;
      w = eff_size(width_reg, MAX_COLUMNS);
      h = eff_size(height_reg, MAX_ROWS);
      row_sum        = row_sum + p;
      row_square_sum = row_square_sum + p * p;
      // the first row has nothing above it
      up_sum    = (row != 0) ? sum_line[col] : '0;
      up_square = (row != 0) ? square_line[col] : '0;
      r.area_sum        = up_sum + row_sum;
      r.area_square_sum = up_square + row_square_sum;
      sum_line[col]    = r.area_sum;
      square_line[col] = r.area_square_sum;
      r.end_of_row   = (col + 1 >= w);
      r.end_of_frame = r.end_of_row && (row + 1 >= h);
      if (r.end_of_row) begin
        col            = 0;
        row_sum        = '0;
        row_square_sum = '0;
        row            = r.end_of_frame ? 0 : row + 1;
      end else begin
        col++;
      end
      pending_areas.push_back(r);
      pixels++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
    endtask

    task check_area(logic [SUM_W-1:0] area, logic [SQ_W-1:0] square, logic eor, logic eof);
      area_result_t want;
      if (pending_areas.size() == 0) begin
        report($sformatf("result with nothing pending, area_sum %0d", area));
        return;
      end
      want = pending_areas.pop_front();
      if (area !== want.area_sum)
        report($sformatf("result %0d area_sum %0d, want %0d", results, area, want.area_sum));
      if (square !== want.area_square_sum)
        report($sformatf("result %0d area_square_sum %0d, want %0d", results, square,
                         want.area_square_sum));
      if (eor !== want.end_of_row)
        report($sformatf("result %0d end_of_row %b, want %b", results, eor, want.end_of_row));
      if (eof !== want.end_of_frame)
        report($sformatf("result %0d end_of_frame %b, want %b", results, eof,
                         want.end_of_frame));
      if (want.end_of_frame) frames++;
      results++;
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIXEL_W-1:0]   in_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SUM_W-1:0]     out_area_sum;
  logic [SQ_W-1:0]      out_area_square_sum;
  logic                 out_end_of_row;
  logic                 out_end_of_frame;

  integral_tracker tracker;
  bit              cfg_taken = 1'b0;
  bit              in_taken = 1'b0;
  int              in_idle_pct = 0;
  int              out_stall_pct = 0;
  int              cycle_count = 0;

  summed_area_table_with_squares_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel            (in_pixel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_area_sum        (out_area_sum),
    .out_area_square_sum (out_area_square_sum),
    .out_end_of_row      (out_end_of_row),
    .out_end_of_frame    (out_end_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // transfer monitor
  always @(posedge clk) begin
    cycle_count++;
    cfg_taken = rst_n && cfg_valid && cfg_ready;
    in_taken  = rst_n && in_valid && in_ready;
    if (cfg_taken) tracker.apply_reg(cfg_index, cfg_data);
    if (in_taken) tracker.predict_pixel(in_pixel);
    if (rst_n && out_valid && out_ready)
      tracker.check_area(out_area_sum, out_area_square_sum, out_end_of_row, out_end_of_frame);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIXEL_W'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
  endtask

  task automatic cfg_stop();
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] p);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  task automatic in_stop();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.pending_areas.size() != 0) @(negedge clk);
  endtask

  // widening is only safe on the first row, where the line store is not read
  task automatic reconfigure();
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int                sel;
    int                cur_w;
    sel   = $urandom_range(0, 9);
    cur_w = tracker.eff_size(tracker.width_reg, MAX_COLUMNS);
    if (sel < 7) begin
      case ($urandom_range(0, 19))
        0:       w = '0;
        1:       w = SIZE_W'($urandom_range(MAX_COLUMNS, 8191));
        default: w = SIZE_W'($urandom_range(1, 12));
      endcase
      if (tracker.row != 0 && tracker.eff_size(w, MAX_COLUMNS) > cur_w)
        w = SIZE_W'($urandom_range(0, cur_w));
      write_reg(REG_FRAME_WIDTH, w);
    end
    if (sel >= 4) begin
      case ($urandom_range(0, 9))
        0:       h = '0;
        1:       h = SIZE_W'($urandom_range(0, 8191));
        default: h = SIZE_W'($urandom_range(1, 6));
      endcase
      write_reg(REG_FRAME_HEIGHT, h);
    end
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, SIZE_W'($urandom));
    cfg_stop();
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    int left;
    int burst;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    wait_drained();
    reconfigure();
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_pixel(pick_pixel());
      left -= burst;
      if (left > 0 && $urandom_range(0, 2) == 0) begin
        in_stop();
        wait_drained();
        reconfigure();
      end
    end
    in_stop();
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // small frame, pixel extremes, writes to unused indexes must not land
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, '1);
    cfg_stop();
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd1);
    send_pixel(8'd254);
    send_pixel(8'd127);
    in_stop();
    wait_drained();

    write_reg(REG_FRAME_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    cfg_stop();
    repeat (5) send_pixel(8'd255);
    in_stop();
    wait_drained();

    // column already past the new width: row ends here
    write_reg(REG_FRAME_WIDTH, 13'd1);
    cfg_stop();
    send_pixel(8'd200);
    in_stop();
    wait_drained();

    // row already past the new height: frame ends here
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    cfg_stop();
    send_pixel(8'd255);
    in_stop();
    wait_drained();

    // zero sizes act as one
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    cfg_stop();
    send_pixel(8'd17);
    send_pixel(8'd255);
    in_stop();
    wait_drained();

    // oversized width acts as a long row, then a narrow width ends it
    write_reg(REG_FRAME_WIDTH, '1);
    cfg_stop();
    repeat (64) send_pixel('1);
    in_stop();
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 13'd1);
    cfg_stop();
    send_pixel('1);
    in_stop();
    wait_drained();

    // oversized height acts as a tall frame, then a short height ends it
    write_reg(REG_FRAME_HEIGHT, 13'd4097);
    cfg_stop();
    repeat (64) send_pixel('1);
    in_stop();
    wait_drained();
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    cfg_stop();
    send_pixel('1);
    in_stop();

    run_random(220, 0, 0);
    run_random(220, 77, 0);
    run_random(220, 0, 77);
    run_random(220, 14, 14);

    wait_drained();
    repeat (8) @(negedge clk);
    $display("%0d pixels and %0d register writes, %0d results checked over %0d frames",
             tracker.pixels, tracker.writes, tracker.results, tracker.frames);
    $display("size clamps, mid-frame resizes, oversized rows and columns, four pacings");
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sat_pkg.sv
hw/rtl/sat_ram.sv
hw/rtl/sat_fifo.sv
hw/rtl/sat_front.sv
hw/rtl/sat_back.sv
hw/rtl/summed_area_table_with_squares_unit.sv
bench/tb_top.sv
